// File: hdl/hqbd_pkg.sv
// ----------------------------------------------------------------------------
// hqbd_pkg
// Shared constants, field widths and register indexes for the heatmap
// quadrangle box decoder.
// ----------------------------------------------------------------------------
package hqbd_pkg;

  // Default and limits of the feature map dimension.
  localparam int MAX_MAP_DIM_DEF = 256;

  // Field widths.
  localparam int SCORE_W     = 16;
  localparam int OFF_W       = 16;
  localparam int TRIG_W      = 16;
  localparam int INV_W       = 16;
  localparam int MAP_WIDTH_W = 9;
  localparam int COORD_W     = 20;
  localparam int NUM_OFF     = 8;

  // Port widths.
  localparam int IN_TDATA_W  = 176;
  localparam int OUT_TDATA_W = 208;
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 16;

  // Coordinate range after saturation.
  localparam int COORD_MAX = 524287;
  localparam int COORD_MIN = -524288;

  // Q.4 cell center plus half pixel is 64 * index + 40; the low six bits.
  localparam logic [5:0] CENTER_FRAC = 6'd40;

  // Shift for Q.18 to Q.4; the rounding term is half of 2^14.
  localparam int ROUND_SHIFT = 14;

  // Register reset values.
  localparam logic [SCORE_W-1:0]     THR_RST   = 16'd32768;
  localparam logic [INV_W-1:0]       INV_RST   = 16'd16384;
  localparam logic [MAP_WIDTH_W-1:0] WIDTH_RST = 9'd160;

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SCORE_THRESHOLD = 4'd0,
    REG_INV_SCALE_X     = 4'd1,
    REG_INV_SCALE_Y     = 4'd2,
    REG_MAP_WIDTH       = 4'd3
  } cfg_reg_t;

endpackage

// File: hdl/hqbd_counter.sv
// ----------------------------------------------------------------------------
// hqbd_counter
// Raster position tracker: column and row of the current cell, restarted by
// the frame start flag and wrapped at the effective map width.
// ----------------------------------------------------------------------------
module hqbd_counter #(
  parameter int MAX_MAP_DIM = hqbd_pkg::MAX_MAP_DIM_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               advance,
  input  logic                               frame_first,
  input  logic [hqbd_pkg::MAP_WIDTH_W-1:0]   map_width,
  output logic [$clog2(MAX_MAP_DIM)-1:0]     col,
  output logic [$clog2(MAX_MAP_DIM)-1:0]     row
);

  localparam int CW  = $clog2(MAX_MAP_DIM);
  localparam int DW  = $clog2(MAX_MAP_DIM + 1);
  localparam int EW  = (DW > hqbd_pkg::MAP_WIDTH_W) ? DW : hqbd_pkg::MAP_WIDTH_W;
  localparam logic [EW-1:0] DIM_MAX = EW'(MAX_MAP_DIM);

  logic [CW-1:0] col_r, col_nxt;
  logic [CW-1:0] row_r, row_nxt;
  logic [EW-1:0] eff_w;
  logic [EW-1:0] col_inc;
  logic [EW-1:0] row_inc;

  // The frame start flag makes this cell the origin.
  assign col = frame_first ? '0 : col_r;
  assign row = frame_first ? '0 : row_r;

  // Effective width: zero acts as one, anything above the limit is clamped.
  always_comb begin
    priority if (map_width == '0) begin
      eff_w = EW'(1);
    end else if (EW'(map_width) > DIM_MAX) begin
      eff_w = DIM_MAX;
    end else begin
      eff_w = EW'(map_width);
    end
  end

  // Next position in raster order.
  always_comb begin
    col_inc = EW'(col) + EW'(1);
    row_inc = EW'(row) + EW'(1);
    if (col_inc >= eff_w) begin
      col_nxt = '0;
      row_nxt = (row_inc >= DIM_MAX) ? '0 : row_inc[CW-1:0];
    end else begin
      col_nxt = col_inc[CW-1:0];
      row_nxt = row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (advance) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// File: hdl/hqbd_corner.sv
// ----------------------------------------------------------------------------
// hqbd_corner
// One corner coordinate: cell center minus offset, scaled by the Q2.14
// reciprocal, rounded to Q.4 and saturated. Two register stages.
// ----------------------------------------------------------------------------
module hqbd_corner #(
  parameter int IDX_W = 8
) (
  input  logic                                 clk,
  input  logic                                 en_mul,
  input  logic                                 en_out,
  input  logic [IDX_W-1:0]                     idx,
  input  logic [hqbd_pkg::OFF_W-1:0]           off,
  input  logic [hqbd_pkg::INV_W-1:0]           inv,
  output logic [hqbd_pkg::COORD_W-1:0]         coord
);

  localparam int OW = hqbd_pkg::OFF_W;
  localparam int VW = (IDX_W + 6 >= OW) ? IDX_W + 8 : OW + 2;
  localparam int PW = VW + hqbd_pkg::INV_W + 1;
  localparam int SW = PW + 1;
  localparam int QW = SW - hqbd_pkg::ROUND_SHIFT;
  localparam logic signed [QW-1:0] Q_MAX = QW'(hqbd_pkg::COORD_MAX);
  localparam logic signed [QW-1:0] Q_MIN = QW'(hqbd_pkg::COORD_MIN);
  localparam logic signed [SW-1:0] HALF  = SW'(1) <<< (hqbd_pkg::ROUND_SHIFT - 1);

  logic signed [VW-1:0]                   base_s;
  logic signed [VW-1:0]                   off_s;
  logic signed [VW-1:0]                   diff;
  logic signed [hqbd_pkg::INV_W:0]        inv_s;
  logic signed [PW-1:0]                   prod_nxt, prod_r;
  logic signed [SW-1:0]                   sum;
  logic signed [QW-1:0]                   quot;
  logic [hqbd_pkg::COORD_W-1:0]           coord_nxt, coord_r;

  // Exact Q.4 distance: 64 * index + 40 - offset, then the scaled product.
  always_comb begin
    base_s   = VW'({idx, hqbd_pkg::CENTER_FRAC});
    off_s    = {{(VW - OW){off[OW-1]}}, off};
    diff     = base_s - off_s;
    inv_s    = {1'b0, inv};
    prod_nxt = diff * inv_s;
  end

  // Round half up to Q.4 and saturate.
  always_comb begin
    sum  = SW'(prod_r) + HALF;
    quot = QW'(sum >>> hqbd_pkg::ROUND_SHIFT);
    priority if (quot > Q_MAX) begin
      coord_nxt = Q_MAX[hqbd_pkg::COORD_W-1:0];
    end else if (quot < Q_MIN) begin
      coord_nxt = Q_MIN[hqbd_pkg::COORD_W-1:0];
    end else begin
      coord_nxt = quot[hqbd_pkg::COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en_mul) begin
      prod_r <= prod_nxt;
    end
    if (en_out) begin
      coord_r <= coord_nxt;
    end
  end

  assign coord = coord_r;

endmodule

// File: hdl/heatmap_quad_box_decode.sv
// ----------------------------------------------------------------------------
// heatmap_quad_box_decode
// Decodes one feature-map cell per transaction into an image-space
// quadrangle when its score is above the configured threshold.
//
//   channel  dir  handshake          payload
//   in_      in   tvalid / tready    tdata: cell fields, tuser: frame start
//   out_     out  tvalid / tready    tdata: quadrangle, score, sin, cos
//   cfg_     in   we (no wait)       addr: register index, wdata: value
//
// One cell is accepted per cycle while in_tready is high; a result passes
// through the input register, product register and result register.
// Cells at or below the threshold advance the position but leave no result.
// Reset clears the position, the stage valids and the registers to defaults.
// A stall on out_tready holds each full stage; in_tready drops only once the
// input register is full and cannot move on.
// ----------------------------------------------------------------------------
module heatmap_quad_box_decode #(
  parameter int MAX_MAP_DIM = hqbd_pkg::MAX_MAP_DIM_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Input stream
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // cell_score, off_x0, off_y0, off_x1, off_y1, off_x2, off_y2, off_x3,
  // off_y3, sin_in, cos_in (16 bits each, lowest first)
  input  logic [hqbd_pkg::IN_TDATA_W-1:0]       in_tdata,
  // frame_first
  input  logic                                  in_tuser,
  // Result stream
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // corner_x0, corner_y0, corner_x1, corner_y1, corner_x2, corner_y2,
  // corner_x3, corner_y3 (20 bits each), box_score, sin_out, cos_out (16 each)
  output logic [hqbd_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // Configuration
  input  logic                                  cfg_we,
  input  logic [hqbd_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [hqbd_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int CW  = $clog2(MAX_MAP_DIM);
  localparam int NO  = hqbd_pkg::NUM_OFF;
  localparam int OW  = hqbd_pkg::OFF_W;
  localparam int SCW = hqbd_pkg::SCORE_W;
  localparam int TW  = hqbd_pkg::TRIG_W;
  localparam int XW  = hqbd_pkg::COORD_W;

  // Configuration registers.
  logic [SCW-1:0]                        thr_r;
  logic [hqbd_pkg::INV_W-1:0]            inv_x_r;
  logic [hqbd_pkg::INV_W-1:0]            inv_y_r;
  logic [hqbd_pkg::MAP_WIDTH_W-1:0]      map_width_r;

  // Stage control.
  logic in_fire, hit;
  logic rdy1, rdy2, rdy3;
  logic s1_v_r, s2_v_r, out_v_r;

  // Stage payload.
  logic [CW-1:0]  ctr_col, ctr_row;
  logic [CW-1:0]  s1_col_r, s1_row_r;
  logic [OW-1:0]  in_off [NO];
  logic [OW-1:0]  s1_off_r [NO];
  logic [SCW-1:0] s1_score_r, s2_score_r, out_score_r;
  logic [TW-1:0]  s1_sin_r, s2_sin_r, out_sin_r;
  logic [TW-1:0]  s1_cos_r, s2_cos_r, out_cos_r;
  logic [XW-1:0]  coord [NO];

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= hqbd_pkg::THR_RST;
      inv_x_r     <= hqbd_pkg::INV_RST;
      inv_y_r     <= hqbd_pkg::INV_RST;
      map_width_r <= hqbd_pkg::WIDTH_RST;
    end else if (cfg_we) begin
      unique case (hqbd_pkg::cfg_reg_t'(cfg_addr))
        hqbd_pkg::REG_SCORE_THRESHOLD: thr_r       <= cfg_wdata[SCW-1:0];
        hqbd_pkg::REG_INV_SCALE_X:     inv_x_r     <= cfg_wdata[hqbd_pkg::INV_W-1:0];
        hqbd_pkg::REG_INV_SCALE_Y:     inv_y_r     <= cfg_wdata[hqbd_pkg::INV_W-1:0];
        hqbd_pkg::REG_MAP_WIDTH:       map_width_r <= cfg_wdata[hqbd_pkg::MAP_WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  // Each stage moves on when the one after it is empty or moving.
  assign rdy3      = !out_v_r || out_tready;
  assign rdy2      = !s2_v_r || rdy3;
  assign rdy1      = !s1_v_r || rdy2;
  assign in_tready = rdy1;
  assign in_fire   = in_tvalid && in_tready;
  assign hit       = in_tdata[SCW-1:0] > thr_r;

  // Raster position of the incoming cell.
  hqbd_counter #(
    .MAX_MAP_DIM (MAX_MAP_DIM)
  ) u_counter (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (in_fire),
    .frame_first (in_tuser),
    .map_width   (map_width_r),
    .col         (ctr_col),
    .row         (ctr_row)
  );

  // Offset fields of the input transaction.
  for (genvar k = 0; k < NO; k++) begin : g_off
    assign in_off[k] = in_tdata[SCW + OW*k +: OW];
  end

  // Stage valids; a cell at or below threshold leaves an empty slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy1) begin
        s1_v_r <= in_fire && hit;
      end
      if (rdy2) begin
        s2_v_r <= s1_v_r;
      end
      if (rdy3) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_col_r   <= ctr_col;
      s1_row_r   <= ctr_row;
      s1_score_r <= in_tdata[SCW-1:0];
      s1_sin_r   <= in_tdata[SCW + OW*NO +: TW];
      s1_cos_r   <= in_tdata[SCW + OW*NO + TW +: TW];
      for (int k = 0; k < NO; k++) begin
        s1_off_r[k] <= in_off[k];
      end
    end
  end

  // Pass-through fields follow the corner pipeline.
  always_ff @(posedge clk) begin
    if (rdy2 && s1_v_r) begin
      s2_score_r <= s1_score_r;
      s2_sin_r   <= s1_sin_r;
      s2_cos_r   <= s1_cos_r;
    end
    if (rdy3 && s2_v_r) begin
      out_score_r <= s2_score_r;
      out_sin_r   <= s2_sin_r;
      out_cos_r   <= s2_cos_r;
    end
  end

  // Eight corner coordinates: even lanes are x, odd lanes are y.
  for (genvar k = 0; k < NO; k++) begin : g_corner
    hqbd_corner #(
      .IDX_W (CW)
    ) u_corner (
      .clk    (clk),
      .en_mul (rdy2 && s1_v_r),
      .en_out (rdy3 && s2_v_r),
      .idx    ((k % 2 == 0) ? s1_col_r : s1_row_r),
      .off    (s1_off_r[k]),
      .inv    ((k % 2 == 0) ? inv_x_r : inv_y_r),
      .coord  (coord[k])
    );
    assign out_tdata[XW*k +: XW] = coord[k];
  end

  assign out_tdata[XW*NO +: SCW]            = out_score_r;
  assign out_tdata[XW*NO + SCW +: TW]       = out_sin_r;
  assign out_tdata[XW*NO + SCW + TW +: TW]  = out_cos_r;
  assign out_tvalid                         = out_v_r;

`ifndef NO_ASSERTIONS
  // A frame start above threshold enters the pipe at the origin.
  a_frame_origin: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tuser && hit |=> s1_v_r && s1_col_r == '0 && s1_row_r == '0)
    else $error("frame start not decoded at the origin");

  // A cell at or below threshold never becomes a result.
  a_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !hit |=> !s1_v_r)
    else $error("cell below threshold entered the pipe");

  // A blocked input stage keeps its item.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !rdy2 |=> s1_v_r && $stable(s1_score_r))
    else $error("input stage lost an item under stall");

  // A blocked product stage keeps its item.
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && !rdy3 |=> s2_v_r && $stable(s2_score_r))
    else $error("product stage lost an item under stall");
`endif

endmodule

// File: tb/hqbd_quad_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hqbd_quad_checker
// Watches the cell, result and register ports of the box decoder. It keeps
// its own copy of the registers and the raster position, predicts the
// quadrangle for each accepted cell, and compares every result, field by
// field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module hqbd_quad_checker #(
  parameter int MAX_DIM = hqbd_pkg::MAX_MAP_DIM_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [hqbd_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                              in_tuser,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [hqbd_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                              cfg_we,
  input  logic [hqbd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [hqbd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output int                                fail_count,
  output int                                pending
);

  localparam int SCORE_W     = hqbd_pkg::SCORE_W;
  localparam int OFF_W       = hqbd_pkg::OFF_W;
  localparam int TRIG_W      = hqbd_pkg::TRIG_W;
  localparam int INV_W       = hqbd_pkg::INV_W;
  localparam int MAP_WIDTH_W = hqbd_pkg::MAP_WIDTH_W;
  localparam int COORD_W     = hqbd_pkg::COORD_W;
  localparam int NUM_OFF     = hqbd_pkg::NUM_OFF;
  localparam int ROUND_SHIFT = hqbd_pkg::ROUND_SHIFT;

  // A cell is 4 pixels wide, which is 64 in Q.4.
  localparam longint CELL_STRIDE_Q4 = 64;

  localparam int OFF_LSB = SCORE_W;
  localparam int SIN_LSB = SCORE_W + NUM_OFF * OFF_W;
  localparam int COS_LSB = SIN_LSB + TRIG_W;
  localparam int BOX_SCORE_LSB = NUM_OFF * COORD_W;
  localparam int BOX_SIN_LSB   = BOX_SCORE_LSB + SCORE_W;
  localparam int BOX_COS_LSB   = BOX_SIN_LSB + TRIG_W;

  typedef struct packed {
    logic [NUM_OFF-1:0][COORD_W-1:0] corner;
    logic [SCORE_W-1:0]              score;
    logic [TRIG_W-1:0]               sin_v;
    logic [TRIG_W-1:0]               cos_v;
  } quad_t;

  // Register copies and raster position.
  logic [SCORE_W-1:0]     thr_reg;
  logic [INV_W-1:0]       inv_x_reg;
  logic [INV_W-1:0]       inv_y_reg;
  logic [MAP_WIDTH_W-1:0] width_reg;
  int unsigned            col_pos;
  int unsigned            row_pos;

  // Quadrangles predicted and not yet seen on the result port.
  quad_t quad_q[$];

  // One image coordinate: cell center plus half pixel, minus the offset,
  // scaled by the Q2.14 reciprocal, rounded half up to Q.4 and saturated.
  function automatic logic [COORD_W-1:0] image_coord(int unsigned idx,
                                                     logic [OFF_W-1:0] off,
                                                     logic [INV_W-1:0] inv);
    longint pos;
    longint prod;
    longint q;
    pos  = longint'(idx) * CELL_STRIDE_Q4 + longint'(hqbd_pkg::CENTER_FRAC)
           - longint'($signed(off));
    prod = pos * longint'(inv);
    q    = (prod + (longint'(1) << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
    if (q > hqbd_pkg::COORD_MAX) q = hqbd_pkg::COORD_MAX;
    if (q < hqbd_pkg::COORD_MIN) q = hqbd_pkg::COORD_MIN;
    return q[COORD_W-1:0];
  endfunction

  always @(posedge clk) begin : watch
    quad_t                      want;
    quad_t                      got;
    logic [NUM_OFF-1:0][OFF_W-1:0] offs;
    logic [SCORE_W-1:0]         score;
    int unsigned                eff_w;
    int                         k;
    if (!rst_n) begin
      thr_reg    <= hqbd_pkg::THR_RST;
      inv_x_reg  <= hqbd_pkg::INV_RST;
      inv_y_reg  <= hqbd_pkg::INV_RST;
      width_reg  <= hqbd_pkg::WIDTH_RST;
      col_pos    = 0;
      row_pos    = 0;
      fail_count = 0;
      quad_q.delete();
    end else begin
      // Result transaction: compare with the oldest prediction.
      if (out_tvalid && out_tready) begin
        got.corner = out_tdata[BOX_SCORE_LSB-1:0];
        got.score  = out_tdata[BOX_SCORE_LSB +: SCORE_W];
        got.sin_v  = out_tdata[BOX_SIN_LSB +: TRIG_W];
        got.cos_v  = out_tdata[BOX_COS_LSB +: TRIG_W];
        if (quad_q.size() == 0) begin
          fail_count++;
          $display("%0t: result expected none, got %h", $time, out_tdata);
        end else begin
          want = quad_q.pop_front();
          for (k = 0; k < NUM_OFF; k++) begin
            if (got.corner[k] !== want.corner[k]) begin
              fail_count++;
              $display("%0t: corner_%s%0d expected %0d got %0d", $time,
                       (k % 2) ? "y" : "x", k / 2, $signed(want.corner[k]),
                       $signed(got.corner[k]));
            end
          end
          if (got.score !== want.score) begin
            fail_count++;
            $display("%0t: box_score expected %h got %h", $time, want.score, got.score);
          end
          if (got.sin_v !== want.sin_v) begin
            fail_count++;
            $display("%0t: sin_out expected %h got %h", $time, want.sin_v, got.sin_v);
          end
          if (got.cos_v !== want.cos_v) begin
            fail_count++;
            $display("%0t: cos_out expected %h got %h", $time, want.cos_v, got.cos_v);
          end
        end
      end

      // Cell transaction: predict the quadrangle, then advance the position.
      if (in_tvalid && in_tready) begin
        score = in_tdata[SCORE_W-1:0];
        offs  = in_tdata[OFF_LSB +: NUM_OFF * OFF_W];
        eff_w = width_reg;
        if (eff_w == 0) eff_w = 1;
        if (eff_w > MAX_DIM) eff_w = MAX_DIM;
        if (in_tuser) begin
          col_pos = 0;
          row_pos = 0;
        end
        if (score > thr_reg) begin
          for (k = 0; k < NUM_OFF; k += 2) begin
            want.corner[k]     = image_coord(col_pos, offs[k], inv_x_reg);
            want.corner[k + 1] = image_coord(row_pos, offs[k + 1], inv_y_reg);
          end
          want.score = score;
          want.sin_v = in_tdata[SIN_LSB +: TRIG_W];
          want.cos_v = in_tdata[COS_LSB +: TRIG_W];
          quad_q.insert(quad_q.size(), want);
        end
        if (col_pos + 1 >= eff_w) begin
          col_pos = 0;
          row_pos = (row_pos + 1 >= MAX_DIM) ? 0 : row_pos + 1;
        end else begin
          col_pos = col_pos + 1;
        end
      end

      // Register writes; indexes past the last register are ignored.
      if (cfg_we) begin
        case (hqbd_pkg::cfg_reg_t'(cfg_addr))
          hqbd_pkg::REG_SCORE_THRESHOLD: thr_reg   <= cfg_wdata[SCORE_W-1:0];
          hqbd_pkg::REG_INV_SCALE_X:     inv_x_reg <= cfg_wdata[INV_W-1:0];
          hqbd_pkg::REG_INV_SCALE_Y:     inv_y_reg <= cfg_wdata[INV_W-1:0];
          hqbd_pkg::REG_MAP_WIDTH:       width_reg <= cfg_wdata[MAP_WIDTH_W-1:0];
          default: ;
        endcase
      end
    end
    pending <= quad_q.size();
  end

endmodule

// File: tb/heatmap_quad_box_decode_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heatmap_quad_box_decode_tb
// Drives feature-map cells and register settings into the box decoder with
// random gaps and result stalls, including one long stall that backs up the
// input, and lets the checker beside the block predict and compare results.
// ----------------------------------------------------------------------------
module heatmap_quad_box_decode_tb;

  localparam int SCORE_W     = hqbd_pkg::SCORE_W;
  localparam int OFF_W       = hqbd_pkg::OFF_W;
  localparam int TRIG_W      = hqbd_pkg::TRIG_W;
  localparam int INV_W       = hqbd_pkg::INV_W;
  localparam int MAP_WIDTH_W = hqbd_pkg::MAP_WIDTH_W;
  localparam int NUM_OFF     = hqbd_pkg::NUM_OFF;
  localparam int IN_TDATA_W  = hqbd_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = hqbd_pkg::OUT_TDATA_W;
  localparam int CFG_ADDR_W  = hqbd_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W  = hqbd_pkg::CFG_DATA_W;

  localparam int IDLE_PCT      = 25;
  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 4000;

  localparam logic [OFF_W-1:0] OFF_MIN = 16'h8000;
  localparam logic [OFF_W-1:0] OFF_MAX = 16'h7FFF;
  localparam logic [SCORE_W-1:0] SCORE_TOP = 16'hFFFF;

  // Register indexes that map to no register.
  localparam int FIRST_UNMAPPED = hqbd_pkg::REG_MAP_WIDTH + 1;
  localparam int LAST_UNMAPPED  = (1 << CFG_ADDR_W) - 1;

  typedef struct packed {
    logic                          first;
    logic [TRIG_W-1:0]             cos_v;
    logic [TRIG_W-1:0]             sin_v;
    logic [NUM_OFF-1:0][OFF_W-1:0] off;
    logic [SCORE_W-1:0]            score;
  } cell_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  logic                   steady;
  logic                   hold_start;
  int                     hold_left = 0;
  int                     fail_count;
  int                     pending;
  logic [SCORE_W-1:0]     cur_thr = hqbd_pkg::THR_RST;

  heatmap_quad_box_decode uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    // cell_score, off_x0 .. off_y3, sin_in, cos_in (16 bits each, lowest first)
    .in_tdata   (in_tdata),
    // frame_first
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    // corner_x0 .. corner_y3 (20 bits each), box_score, sin_out, cos_out
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  hqbd_quad_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: random stalls, or one long stall when requested.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_start) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
    end else begin
      out_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Offsets favor the extremes now and then.
  function automatic logic [OFF_W-1:0] pick_offset();
    case ($urandom_range(0, 9))
      0: return OFF_MIN;
      1: return OFF_MAX;
      2: return '0;
      default: return OFF_W'($urandom);
    endcase
  endfunction

  // Scores cluster around the current threshold to hit both sides of it.
  function automatic cell_t random_cell(logic first);
    cell_t cv;
    int    k;
    cv.first = first;
    case ($urandom_range(0, 7))
      0: cv.score = cur_thr;
      1: cv.score = cur_thr + 1'b1;
      2: cv.score = cur_thr - 1'b1;
      3: cv.score = '0;
      4: cv.score = SCORE_TOP;
      default: cv.score = SCORE_W'($urandom);
    endcase
    for (k = 0; k < NUM_OFF; k++) cv.off[k] = pick_offset();
    cv.sin_v = TRIG_W'($urandom);
    cv.cos_v = TRIG_W'($urandom);
    return cv;
  endfunction

  // Offer one cell, with random gaps before it, until it is taken.
  task automatic send_cell(cell_t cv);
    if (!steady) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cv.first;
    in_tdata  <= {cv.cos_v, cv.sin_v, cv.off, cv.score};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // A run of cells; frames restart at random unless ff_pct is zero.
  task automatic run_cells(int n, bit lead_first, int ff_pct);
    int i;
    for (i = 0; i < n; i++)
      send_cell(random_cell((i == 0 && lead_first) || ($urandom_range(0, 99) < ff_pct)));
  endtask

  // Wait for every predicted result, then let the pipeline settle.
  task automatic drain();
    int guard;
    guard = 0;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0 && guard < DRAIN_LIMIT) begin
      guard++;
      @(posedge clk);
    end
    if (guard >= DRAIN_LIMIT) begin
      $display("heatmap_quad_box_decode test failed");
      $finish;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all registers, then a write to an unmapped index that must be
  // ignored. Unused high bits of the width write carry noise.
  task automatic set_regs(logic [SCORE_W-1:0] thr, logic [INV_W-1:0] ix,
                          logic [INV_W-1:0] iy, logic [MAP_WIDTH_W-1:0] w);
    cfg_we    <= 1'b1;
    cfg_addr  <= hqbd_pkg::REG_SCORE_THRESHOLD;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_addr  <= hqbd_pkg::REG_INV_SCALE_X;
    cfg_wdata <= ix;
    @(posedge clk);
    cfg_addr  <= hqbd_pkg::REG_INV_SCALE_Y;
    cfg_wdata <= iy;
    @(posedge clk);
    cfg_addr  <= hqbd_pkg::REG_MAP_WIDTH;
    cfg_wdata <= {7'($urandom), w};
    @(posedge clk);
    cfg_addr  <= CFG_ADDR_W'($urandom_range(FIRST_UNMAPPED, LAST_UNMAPPED));
    cfg_wdata <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_thr   = thr;
  endtask

  // Overall time limit.
  initial begin
    #1_000_000;
    $display("heatmap_quad_box_decode test failed");
    $finish;
  end

  initial begin
    cell_t cv;
    int    i;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tuser   <= 1'b0;
    in_tdata   <= '0;
    cfg_we     <= 1'b0;
    cfg_addr   <= '0;
    cfg_wdata  <= '0;
    steady     <= 1'b0;
    hold_start <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed cells under the reset register values.
    for (i = 0; i < 20; i++) begin
      cv = random_cell(i == 0);
      case (i)
        0: begin
          cv.score = SCORE_TOP;
          cv.off   = {NUM_OFF{OFF_MIN}};
          cv.sin_v = OFF_MIN;
          cv.cos_v = OFF_MAX;
        end
        1: begin
          cv.score = cur_thr + 1'b1;
          cv.off   = {NUM_OFF{OFF_MAX}};
          cv.sin_v = OFF_MAX;
          cv.cos_v = OFF_MIN;
        end
        // Exactly at the threshold: no box.
        2: cv.score = cur_thr;
        3: begin
          cv.score = '0;
          cv.off   = '0;
        end
        4: begin
          cv.score = cur_thr + 1'b1;
          cv.off   = '0;
          cv.sin_v = '0;
          cv.cos_v = '0;
        end
        // Frame restart in the middle of a row.
        5: begin
          cv.first = 1'b1;
          cv.score = SCORE_TOP;
          cv.off   = '1;
        end
        default: cv.score = (i % 2) ? SCORE_TOP : SCORE_W'($urandom);
      endcase
      send_cell(cv);
    end
    drain();

    // Narrower width mid-frame, with a long result stall to back up the input.
    set_regs(16'h4000, 16'h4000, 16'h4000, 9'd8);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    run_cells(40, 1'b0, 3);
    drain();

    // Scale extremes, short frames.
    set_regs('0, 16'hFFFF, '0, 9'd5);
    run_cells(30, 1'b1, 8);
    drain();

    // Highest threshold: nothing can pass.
    set_regs(16'hFFFF, 16'h2000, 16'h6000, 9'd3);
    run_cells(10, 1'b1, 5);
    drain();

    // Width above the maximum clamps; no idling on either side.
    steady <= 1'b1;
    set_regs(16'h0800, 16'h1000, 16'h3000, 9'd300);
    run_cells(262, 1'b1, 0);
    drain();
    steady <= 1'b0;

    // Width zero acts as one: every cell is a new row, and the row wraps.
    set_regs(16'h4000, INV_W'($urandom), INV_W'($urandom), 9'd0);
    run_cells(258, 1'b1, 0);
    drain();

    // Random settings with small maps.
    for (i = 0; i < 2; i++) begin
      set_regs(SCORE_W'($urandom_range(0, 16'hC000)), INV_W'($urandom), INV_W'($urandom),
               MAP_WIDTH_W'($urandom_range(1, 20)));
      run_cells(20, 1'b1, 5);
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("heatmap_quad_box_decode test passed");
    end else begin
      $display("heatmap_quad_box_decode test failed");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/hqbd_pkg.sv
hdl/hqbd_counter.sv
hdl/hqbd_corner.sv
hdl/heatmap_quad_box_decode.sv
tb/hqbd_quad_checker.sv
tb/heatmap_quad_box_decode_tb.sv
